>>> rtl/cdp_pkg.sv
package cdp_pkg;

  localparam int MAX_ORDER = 1024;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ORD_W     = IDX_W + 1;
  localparam int CFG_W     = 11;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int SUM_W     = 48;
  localparam int COL_W     = 10;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] matrix_value;
    logic signed [VAL_W-1:0] vector_value;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]        column_index;
    logic signed [SUM_W-1:0] dot_value;
    logic                    last_column;
  } res_word_t;

  // classified work for the accumulate side
  typedef struct packed {
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] prod;
    logic                     first_row;
    logic                     last_row;
    logic                     last_col;
  } cmd_t;

endpackage

>>> rtl/column_dot_product_engine.sv
// column dot product engine: streams a square matrix in row-major order, one
// element per word together with the vector element of its row, and returns
// the product of the transposed matrix with the vector. operands are signed
// q8.8, sums are signed q32.16 held in 48 bits and saturated. during the last
// row every input word yields one result word (column index, finished sum,
// last-column flag); earlier rows yield none. one word is taken per cycle
// while full is low: the rate is set by the single multiply in the front and
// the one read-modify-write of the 1024 x 48 sum memory per cycle in the back,
// with the last write bypassed so that even order one runs at full rate. a
// result word reaches the result ports through the command queue, accumulate
// stage and result queue. full rises only when the four-word command queue
// fills, which happens when the back stalls on a full four-word result queue.
// sum memory is not cleared after reset: the first row writes every column
// before any later row reads it. writing the order register restarts the
// matrix at row zero; write it only while no words are in flight
module column_dot_product_engine (
  input  logic               clk,
  input  logic               rst,
  // order register
  input  logic               cfg_we,
  input  logic [10:0]        cfg_data,
  // input word queue
  input  logic               push,
  output logic               full,
  input  cdp_pkg::in_word_t  item,
  // result word queue
  output logic               empty,
  input  logic               pop,
  output cdp_pkg::res_word_t result
);

  import cdp_pkg::*;

  // front to back command path
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;

  // front: counters, order clamp, multiply and row/column classification
  cdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .queue_full(full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // short queue so each side can stall on its own
  cdp_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .cmd_in(cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .head  (cmd_head)
  );

  // back: sum memory read-modify-write, saturation and result queue
  cdp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

>>> rtl/cdp_ram.sv
module cdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cdp_cmd_queue.sv
module cdp_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cdp_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output cdp_pkg::cmd_t head
);

  import cdp_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t             store [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W+1)'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(CMD_DEPTH))
    else $error("command queue overfilled");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !empty)
    else $error("command queue lost a word");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> !full)
    else $error("command queue count stuck after pop");
`endif

endmodule

>>> rtl/cdp_front.sv
module cdp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_data,
  input  logic              push,
  input  cdp_pkg::in_word_t item,
  input  logic              queue_full,
  output logic              cmd_push,
  output cdp_pkg::cmd_t     cmd
);

  import cdp_pkg::*;

  logic [CFG_W-1:0]         size_in_use;
  logic [IDX_W-1:0]         row_count;
  logic [IDX_W-1:0]         col_count;
  logic [ORD_W-1:0]         order;
  logic [IDX_W-1:0]         col;
  logic                     row_end;
  logic                     col_end;
  logic signed [PROD_W-1:0] prod;
  logic                     accept;

  // order zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (size_in_use == '0) begin
      order = ORD_W'(1);
    end else if (32'(size_in_use) > 32'(MAX_ORDER)) begin
      order = ORD_W'(MAX_ORDER);
    end else begin
      order = ORD_W'(size_in_use);
    end
  end

  assign col     = (ORD_W'(col_count) >= order) ? IDX_W'(order - ORD_W'(1)) : col_count;
  assign row_end = (ORD_W'(row_count) + ORD_W'(1)) >= order;
  assign col_end = (ORD_W'(col) + ORD_W'(1)) >= order;
  assign prod    = PROD_W'(item.matrix_value) * PROD_W'(item.vector_value);
  assign accept  = push && !queue_full;

  assign cmd_push      = accept;
  assign cmd.col       = col;
  assign cmd.prod      = prod;
  assign cmd.first_row = (row_count == '0);
  assign cmd.last_row  = row_end;
  assign cmd.last_col  = col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
      row_count   <= '0;
      col_count   <= '0;
    end else if (cfg_we) begin
      size_in_use <= cfg_data;
      row_count   <= '0;
      col_count   <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : row_count + IDX_W'(1);
      end else begin
        col_count <= col + IDX_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ORD_W'(col_count) < order)
    else $error("column counter beyond order");
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    ORD_W'(row_count) < order)
    else $error("row counter beyond order");
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && col_end && row_end && !cfg_we) |=> (row_count == '0 && col_count == '0))
    else $error("counters did not wrap at end of matrix");
`endif

endmodule

>>> rtl/cdp_back.sv
module cdp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  cdp_pkg::cmd_t      cmd_head,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output cdp_pkg::res_word_t result
);

  import cdp_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);

  cmd_t                    s2;
  logic                    s2_valid;
  logic                    s2_fire;
  logic [SUM_W-1:0]        ram_rdata;
  logic signed [SUM_W-1:0] old_sum;
  logic signed [SUM_W:0]   wide;
  logic signed [SUM_W-1:0] acc;
  logic                    fwd_valid;
  logic [IDX_W-1:0]        fwd_col;
  logic signed [SUM_W-1:0] fwd_sum;

  res_word_t        store [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             out_full;
  logic             out_push;
  logic             out_pop;
  res_word_t        res_in;

  assign out_full = (count == (PTR_W+1)'(OUT_DEPTH));
  assign empty    = (count == '0);
  assign result   = store[rd_ptr];
  assign out_pop  = pop && !empty;

  // stage two retires unless its result has nowhere to go
  assign s2_fire  = s2_valid && (!s2.last_row || !out_full);
  assign cmd_pop  = !cmd_empty && (!s2_valid || s2_fire);
  assign out_push = s2_fire && s2.last_row;

  cdp_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_ORDER)
  ) u_sums (
    .clk  (clk),
    .we   (s2_fire),
    .waddr(s2.col),
    .wdata(acc),
    .re   (cmd_pop),
    .raddr(cmd_head.col),
    .rdata(ram_rdata)
  );

  // last write bypasses the memory when it landed after the read
  assign old_sum = (fwd_valid && fwd_col == s2.col) ? fwd_sum : $signed(ram_rdata);
  assign wide    = {old_sum[SUM_W-1], old_sum}
                 + {{(SUM_W+1-PROD_W){s2.prod[PROD_W-1]}}, s2.prod};

  always_comb begin
    if (s2.first_row) begin
      acc = {{(SUM_W-PROD_W){s2.prod[PROD_W-1]}}, s2.prod};
    end else if (wide[SUM_W] != wide[SUM_W-1]) begin
      acc = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      acc = wide[SUM_W-1:0];
    end
  end

  assign res_in.column_index = COL_W'(s2.col);
  assign res_in.dot_value    = acc;
  assign res_in.last_column  = s2.last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (cmd_pop) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (s2_fire) begin
        fwd_valid <= 1'b1;
      end
      if (out_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (out_push && !out_pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (out_pop && !out_push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s2 <= cmd_head;
    end
    if (s2_fire) begin
      fwd_col <= s2.col;
      fwd_sum <= acc;
    end
    if (out_push) begin
      store[wr_ptr] <= res_in;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_fire) |=> (s2_valid && $stable(s2)))
    else $error("stalled accumulate stage changed");
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    out_push |=> !empty)
    else $error("result word lost");
  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(OUT_DEPTH))
    else $error("result queue overfilled");
`endif

endmodule
